>>> hdl/atilt_pkg.sv
// Shared types, constants and helper functions of the tilt angle pipeline.
package atilt_pkg;

  // Datapath word: scaled samples plus CORDIC growth
  localparam int W = 64;
  // Angle accumulator in units of 1/65536 degree
  localparam int ANG_W = 32;
  // Scaled samples sit at bit 60 regardless of sample width
  localparam int TOP_BIT = 60;
  // CORDIC gain K as round(K * 2^20)
  localparam int GAIN_FRAC = 20;
  localparam int GAIN_W = 22;
  localparam logic signed [GAIN_W-1:0] GAIN_Q20 = 22'sd1726753;
  localparam int ANG_FRAC = 16;

  localparam logic signed [ANG_W-1:0] DEG90  = 32'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG180 = 32'sd11796480;

  // atan(2^-i) in units of 1/65536 degree
  localparam logic signed [ANG_W-1:0] STAGE_ANGLE [24] = '{
    32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945, 32'sd234379, 32'sd117304,
    32'sd58666, 32'sd29335, 32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
    32'sd917, 32'sd458, 32'sd229, 32'sd115, 32'sd57, 32'sd29,
    32'sd14, 32'sd7, 32'sd4, 32'sd2, 32'sd1, 32'sd0
  };

  // One vector under rotation, with its accumulated angle
  typedef struct packed {
    logic signed [W-1:0]     x;
    logic signed [W-1:0]     y;
    logic signed [ANG_W-1:0] z;
  } cordic_t;

  // Axis and origin cases decided at chain entry
  typedef struct packed {
    logic                    hit;
    logic                    zero;
    logic signed [ANG_W-1:0] ang;
  } spc_t;

  // Rotate a left half-plane vector by +-90 degrees into the right half-plane
  function automatic cordic_t prerot(input logic signed [W-1:0] px,
                                     input logic signed [W-1:0] py);
    cordic_t c;
    c.x = px;
    c.y = py;
    c.z = '0;
    if (px[W-1]) begin
      if (!py[W-1]) begin
        c.x = py;
        c.y = -px;
        c.z = DEG90;
      end else begin
        c.x = -py;
        c.y = px;
        c.z = -DEG90;
      end
    end
    return c;
  endfunction

  // Exact answers on the axes and at the origin
  function automatic spc_t special(input logic signed [W-1:0] px,
                                   input logic signed [W-1:0] py);
    spc_t s;
    s.zero = (px == '0) && (py == '0);
    s.hit  = (px == '0) || (py == '0);
    if (s.zero) begin
      s.ang = '0;
    end else if (py == '0) begin
      s.ang = (px > 0) ? '0 : DEG180;
    end else begin
      s.ang = (py > 0) ? DEG90 : -DEG90;
    end
    return s;
  endfunction

endpackage

>>> hdl/accel_tilt_angles_top.sv
// Registers in order: roll entry, roll cells, pitch entry, pitch cells, output.
// Throughput: one sample per cycle; two chains of CORDIC cells, roll then pitch.
// The whole pipeline advances when the output register is empty or taken,
// so a stalled result holds every stage behind it.
// Reset (rst, synchronous) clears all stage valid flags but no data registers.
// Top level: tilt angles from a three-axis accelerometer sample.
module accel_tilt_angles_top #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0]    accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0]    accel_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ANGLE_FRAC_BITS+8:0] roll_angle,
  output logic signed [ANGLE_FRAC_BITS+7:0] pitch_angle
);

  localparam int W      = atilt_pkg::W;
  localparam int ANG_W  = atilt_pkg::ANG_W;
  localparam int PROD_W = SAMPLE_WIDTH + atilt_pkg::GAIN_W;
  localparam int IN_SH  = atilt_pkg::TOP_BIT - SAMPLE_WIDTH;
  localparam int NX_SH  = IN_SH - atilt_pkg::GAIN_FRAC;
  localparam int RND_SH = atilt_pkg::ANG_FRAC - ANGLE_FRAC_BITS;
  localparam int ROLL_W = ANGLE_FRAC_BITS + 9;
  localparam int PIT_W  = ANGLE_FRAC_BITS + 8;
  localparam logic signed [ANG_W-1:0] HALF = ANG_W'(1) <<< (RND_SH - 1);

  logic en;

  // Roll chain taps
  logic                      roll_v   [CORDIC_STAGES+1];
  atilt_pkg::cordic_t        roll_q   [CORDIC_STAGES+1];
  atilt_pkg::spc_t           rspc_q   [CORDIC_STAGES+1];
  logic signed [PROD_W-1:0]  prod_q   [CORDIC_STAGES+1];

  // Pitch chain taps
  logic                      pit_v    [CORDIC_STAGES+1];
  atilt_pkg::cordic_t        pit_q    [CORDIC_STAGES+1];
  atilt_pkg::spc_t           pspc_q   [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0]   rang_q   [CORDIC_STAGES+1];

  logic signed [W-1:0] zs;
  logic signed [W-1:0] ys;
  logic signed [W-1:0] mag;
  logic signed [W-1:0] nx;
  logic signed [ANG_W-1:0] roll_res;
  logic signed [ANG_W-1:0] pit_res;
  logic signed [ANG_W-1:0] roll_sat;
  logic signed [ANG_W-1:0] pit_sat;
  logic signed [ANG_W-1:0] roll_rnd;
  logic signed [ANG_W-1:0] pit_rnd;

  // Advance everything while the output register can take a beat
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Scale the samples to the top of the word
  assign zs = W'(accel_z) <<< IN_SH;
  assign ys = W'(accel_y) <<< IN_SH;

  // Entry stage: pre-rotate, flag axis cases, scale x by the gain
  always_ff @(posedge clk) begin
    if (rst) begin
      roll_v[0] <= 1'b0;
    end else if (en) begin
      roll_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_q[0] <= atilt_pkg::prerot(zs, ys);
      rspc_q[0] <= atilt_pkg::special(zs, ys);
      prod_q[0] <= PROD_W'(accel_x) * PROD_W'(atilt_pkg::GAIN_Q20);
    end
  end

  // Roll cells, with side data carried alongside
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_roll
    atilt_cell #(.STAGE(k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (roll_v[k]),
      .in_vec  (roll_q[k]),
      .out_vld (roll_v[k+1]),
      .out_vec (roll_q[k+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        rspc_q[k+1] <= rspc_q[k];
        prod_q[k+1] <= prod_q[k];
      end
    end
  end

  // Resolve roll and set up the pitch vector
  always_comb begin
    roll_res = rspc_q[CORDIC_STAGES].hit ? rspc_q[CORDIC_STAGES].ang
                                         : roll_q[CORDIC_STAGES].z;
    mag      = rspc_q[CORDIC_STAGES].zero ? '0 : roll_q[CORDIC_STAGES].x;
    nx       = (-W'(prod_q[CORDIC_STAGES])) <<< NX_SH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pit_v[0] <= 1'b0;
    end else if (en) begin
      pit_v[0] <= roll_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pit_q[0]  <= atilt_pkg::prerot(mag, nx);
      pspc_q[0] <= atilt_pkg::special(mag, nx);
      rang_q[0] <= roll_res;
    end
  end

  // Pitch cells
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_pitch
    atilt_cell #(.STAGE(k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (pit_v[k]),
      .in_vec  (pit_q[k]),
      .out_vld (pit_v[k+1]),
      .out_vec (pit_q[k+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        pspc_q[k+1] <= pspc_q[k];
        rang_q[k+1] <= rang_q[k];
      end
    end
  end

  // Saturate and round both angles to the output unit
  always_comb begin
    pit_res = pspc_q[CORDIC_STAGES].hit ? pspc_q[CORDIC_STAGES].ang
                                        : pit_q[CORDIC_STAGES].z;
    roll_sat = rang_q[CORDIC_STAGES];
    if (roll_sat > atilt_pkg::DEG180) begin
      roll_sat = atilt_pkg::DEG180;
    end else if (roll_sat < -atilt_pkg::DEG180) begin
      roll_sat = -atilt_pkg::DEG180;
    end
    pit_sat = pit_res;
    if (pit_sat > atilt_pkg::DEG90) begin
      pit_sat = atilt_pkg::DEG90;
    end else if (pit_sat < -atilt_pkg::DEG90) begin
      pit_sat = -atilt_pkg::DEG90;
    end
    roll_rnd = (roll_sat + HALF) >>> RND_SH;
    pit_rnd  = (pit_sat + HALF) >>> RND_SH;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= pit_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle  <= roll_rnd[ROLL_W-1:0];
      pitch_angle <= pit_rnd[PIT_W-1:0];
    end
  end

endmodule

>>> hdl/atilt_cell.sv
// One CORDIC vectoring micro-rotation with its output register.
module atilt_cell #(
  parameter int STAGE = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  atilt_pkg::cordic_t in_vec,
  output logic               out_vld,
  output atilt_pkg::cordic_t out_vec
);

  atilt_pkg::cordic_t vec_next;
  logic signed [atilt_pkg::W-1:0] dx;
  logic signed [atilt_pkg::W-1:0] dy;

  // Rotate towards the x axis by the stage angle
  always_comb begin
    dx = in_vec.y >>> STAGE;
    dy = in_vec.x >>> STAGE;
    if (!in_vec.y[atilt_pkg::W-1]) begin
      vec_next.x = in_vec.x + dx;
      vec_next.y = in_vec.y - dy;
      vec_next.z = in_vec.z + atilt_pkg::STAGE_ANGLE[STAGE];
    end else begin
      vec_next.x = in_vec.x - dx;
      vec_next.y = in_vec.y + dy;
      vec_next.z = in_vec.z - atilt_pkg::STAGE_ANGLE[STAGE];
    end
  end

  // Hand the beat to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec <= vec_next;
    end
  end

endmodule

>>> hdl/atilt_checker.sv
// Port-level checks of the tilt angle block, bound to the top level.
module atilt_checker #(
  parameter int ANGLE_FRAC_BITS = 6
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ANGLE_FRAC_BITS+8:0] roll_angle,
  input logic signed [ANGLE_FRAC_BITS+7:0] pitch_angle
);

  localparam int ROLL_LIM = 180 << ANGLE_FRAC_BITS;
  localparam int PIT_LIM  = 90 << ANGLE_FRAC_BITS;

  // Drop results on reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat survived reset");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(roll_angle) && $stable(pitch_angle))
    else $error("stalled result changed");

  // Take input while the output side is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Keep angles inside their ranges
  a_roll_rng: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(roll_angle) <= ROLL_LIM) && (int'(roll_angle) >= -ROLL_LIM))
    else $error("roll out of range");

  a_pit_rng: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(pitch_angle) <= PIT_LIM) && (int'(pitch_angle) >= -PIT_LIM))
    else $error("pitch out of range");

endmodule

bind accel_tilt_angles_top atilt_checker #(
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_atilt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .roll_angle  (roll_angle),
  .pitch_angle (pitch_angle)
);
